// ===== design/mtx_pkg.sv =====
`timescale 1ns / 1ps

package mtx_pkg;

    // Table sizing.
    localparam int NUM_MUTEXES = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int PID_BITS    = 8;

    localparam int IDX_W  = (NUM_MUTEXES > 1) ? $clog2(NUM_MUTEXES) : 1;
    localparam int QLEN_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ROW_W  = QUEUE_DEPTH * PID_BITS;

    // Field widths on the stream ports.
    localparam int OPCODE_W   = 2;
    localparam int MUTEX_ID_W = 4;
    localparam int PID_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int CREATED_W  = 4;

    // Request opcodes.
    localparam logic [OPCODE_W-1:0] OP_CREATE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOCK   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_UNLOCK = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BLOCKED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic can_load;
    } t_dp_stat;

endpackage

// ===== design/mtx_ctrl.sv =====
`timescale 1ns / 1ps

module mtx_ctrl
    import mtx_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state: capture a request, then execute it once the result register is free.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.can_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands to the datapath.
    assign o_s_tready    = (r_state == S_IDLE);
    assign o_cmd.capture = (r_state == S_IDLE) && i_s_tvalid;
    assign o_cmd.execute = (r_state == S_EXEC) && i_stat.can_load;

endmodule

// ===== design/mtx_dp.sv =====
`timescale 1ns / 1ps

module mtx_dp
    import mtx_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  logic [OPCODE_W-1:0]   i_opcode,
    input  logic [MUTEX_ID_W-1:0] i_mutex_id,
    input  logic [PID_W-1:0]      i_requester_pid,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [STATUS_W-1:0]   o_status,
    output logic [CREATED_W-1:0]  o_created_id,
    output logic                  o_wake_valid,
    output logic [PID_W-1:0]      o_woken_pid
);

    // Entry table, cleared by reset.
    logic [NUM_MUTEXES-1:0] r_used;
    logic [NUM_MUTEXES-1:0] r_locked;
    logic [PID_BITS-1:0]    r_owner [NUM_MUTEXES];
    logic [QLEN_W-1:0]      r_qlen  [NUM_MUTEXES];

    // Wait queue memory: one row of QUEUE_DEPTH slots per mutex.
    logic [ROW_W-1:0] queue_mem [NUM_MUTEXES];
    logic [ROW_W-1:0] r_row;

    // Captured request.
    logic [OPCODE_W-1:0]   r_op;
    logic [MUTEX_ID_W-1:0] r_id;
    logic [PID_BITS-1:0]   r_pid;

    // Result register.
    logic                 r_out_valid;
    logic [STATUS_W-1:0]  r_status;
    logic [CREATED_W-1:0] r_created;
    logic                 r_wake_valid;
    logic [PID_W-1:0]     r_woken_pid;

    logic [IDX_W-1:0]     idx;
    logic [IDX_W-1:0]     rd_addr;
    logic                 in_range;
    logic                 cur_used;
    logic                 cur_locked;
    logic [PID_BITS-1:0]  cur_owner;
    logic [QLEN_W-1:0]    cur_qlen;
    logic [PID_BITS-1:0]  head;
    logic                 hit;
    logic                 free_found;
    logic [IDX_W-1:0]     free_idx;

    logic [STATUS_W-1:0]  n_status;
    logic [CREATED_W-1:0] n_created;
    logic                 n_wake_valid;
    logic [PID_W-1:0]     n_woken_pid;
    logic                 e_we;
    logic [IDX_W-1:0]     e_idx;
    logic                 e_used;
    logic                 e_locked;
    logic [PID_BITS-1:0]  e_owner;
    logic [QLEN_W-1:0]    e_qlen;
    logic                 row_we;
    logic [ROW_W-1:0]     row_wdata;

    // Addressed entry fields.
    assign idx        = r_id[IDX_W-1:0];
    assign in_range   = (int'(r_id) < NUM_MUTEXES);
    assign cur_used   = r_used[idx];
    assign cur_locked = r_locked[idx];
    assign cur_owner  = r_owner[idx];
    assign cur_qlen   = r_qlen[idx];
    assign head       = r_row[PID_BITS-1:0];

    // The queue row is read with the incoming id when a request is captured, else with the held id.
    assign rd_addr = i_cmd.capture ? i_mutex_id[IDX_W-1:0] : idx;

    // Is the caller already waiting in the queue?
    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if ((QLEN_W'(i) < cur_qlen) && (r_row[i*PID_BITS +: PID_BITS] == r_pid)) begin
                hit = 1'b1;
            end
        end
    end

    // Lowest unused entry for create.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NUM_MUTEXES - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Request decode and entry update.
    always_comb begin
        n_status     = ST_ERROR;
        n_created    = '0;
        n_wake_valid = 1'b0;
        n_woken_pid  = '0;
        e_we         = 1'b0;
        e_idx        = idx;
        e_used       = cur_used;
        e_locked     = cur_locked;
        e_owner      = cur_owner;
        e_qlen       = cur_qlen;
        row_we       = 1'b0;
        row_wdata    = r_row;
        case (r_op)
            OP_CREATE: begin
                if (free_found) begin
                    e_we      = 1'b1;
                    e_idx     = free_idx;
                    e_used    = 1'b1;
                    e_locked  = 1'b0;
                    e_owner   = '0;
                    e_qlen    = '0;
                    n_status  = ST_OK;
                    n_created = CREATED_W'(free_idx);
                end
            end
            OP_LOCK: begin
                if (in_range && cur_used) begin
                    if (!cur_locked) begin
                        e_we     = 1'b1;
                        e_locked = 1'b1;
                        e_owner  = r_pid;
                        n_status = ST_OK;
                    end else if (cur_owner == r_pid) begin
                        n_status = ST_OK;
                    end else if (hit) begin
                        n_status = ST_BLOCKED;
                    end else if (cur_qlen >= QLEN_W'(QUEUE_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        // Append the caller at the tail of the queue.
                        for (int i = 0; i < QUEUE_DEPTH; i++) begin
                            if (QLEN_W'(i) == cur_qlen) begin
                                row_wdata[i*PID_BITS +: PID_BITS] = r_pid;
                            end
                        end
                        row_we   = 1'b1;
                        e_we     = 1'b1;
                        e_qlen   = cur_qlen + QLEN_W'(1);
                        n_status = ST_BLOCKED;
                    end
                end
            end
            OP_UNLOCK: begin
                if (in_range && cur_used && cur_locked && (cur_owner == r_pid)) begin
                    n_status = ST_OK;
                    e_we     = 1'b1;
                    if (cur_qlen != '0) begin
                        // Hand off to the oldest waiter and shift the queue down.
                        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                            row_wdata[i*PID_BITS +: PID_BITS] =
                                r_row[(i+1)*PID_BITS +: PID_BITS];
                        end
                        row_we   = 1'b1;
                        e_owner  = head;
                        e_locked = 1'b1;
                        e_qlen   = cur_qlen - QLEN_W'(1);
                        if (head != '0) begin
                            n_wake_valid = 1'b1;
                            n_woken_pid  = PID_W'(head);
                        end
                    end else begin
                        e_locked = 1'b0;
                        e_owner  = '0;
                    end
                end
            end
            default: begin
                n_status = ST_ERROR;
            end
        endcase
    end

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_opcode;
            r_id  <= i_mutex_id;
            r_pid <= i_requester_pid[PID_BITS-1:0];
        end
    end

    // Entry table write-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_locked <= '0;
            for (int i = 0; i < NUM_MUTEXES; i++) begin
                r_owner[i] <= '0;
                r_qlen[i]  <= '0;
            end
        end else if (i_cmd.execute && e_we) begin
            r_used[e_idx]   <= e_used;
            r_locked[e_idx] <= e_locked;
            r_owner[e_idx]  <= e_owner;
            r_qlen[e_idx]   <= e_qlen;
        end
    end

    // Queue memory with registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && row_we) begin
            queue_mem[idx] <= row_wdata;
        end
        r_row <= queue_mem[rd_addr];
    end

    // Result register: valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.execute) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register: payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_status     <= n_status;
            r_created    <= n_created;
            r_wake_valid <= n_wake_valid;
            r_woken_pid  <= n_woken_pid;
        end
    end

    assign o_stat.can_load = !r_out_valid || i_m_tready;
    assign o_m_tvalid      = r_out_valid;
    assign o_status        = r_status;
    assign o_created_id    = r_created;
    assign o_wake_valid    = r_wake_valid;
    assign o_woken_pid     = r_woken_pid;

endmodule

// ===== design/mutex_table_with_fifo_handoff.sv =====
`timescale 1ns / 1ps

// Channel   Dir   Ports           Contents
// request   in    i_s_axis_*      tuser: opcode; tdata: mutex_id, requester_pid
// result    out   o_m_axis_*      tuser: wake_valid; tdata: status, created_id, woken_pid
//
// A request is first captured, and its queue row is read from the queue memory;
// then the entry and the row are updated and the result is loaded.
// The result register frees the input side while a result waits to be taken.
// A stalled result holds back the update of the next request until it is taken.
// Reset clears the entry table and all queue lengths at once; no clearing pass.

module mutex_table_with_fifo_handoff
    import mtx_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [3:0] mutex_id, [11:4] requester_pid
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [1:0] status, [5:2] created_id, [13:6] woken_pid
    output logic        o_m_axis_tuser    // [0] wake_valid
);

    t_dp_cmd              cmd;
    t_dp_stat             stat;
    logic [STATUS_W-1:0]  status;
    logic [CREATED_W-1:0] created_id;
    logic                 wake_valid;
    logic [PID_W-1:0]     woken_pid;

    // Sequencer.
    mtx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Entry table, wait queues and result register.
    mtx_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_opcode        (i_s_axis_tuser),
        .i_mutex_id      (i_s_axis_tdata[3:0]),
        .i_requester_pid (i_s_axis_tdata[11:4]),
        .i_m_tready      (i_m_axis_tready),
        .o_m_tvalid      (o_m_axis_tvalid),
        .o_status        (status),
        .o_created_id    (created_id),
        .o_wake_valid    (wake_valid),
        .o_woken_pid     (woken_pid)
    );

    // Result beat packing.
    assign o_m_axis_tdata = {2'b00, woken_pid, created_id, status};
    assign o_m_axis_tuser = wake_valid;

    // A request beat is never followed by another in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request accepted in back-to-back cycles");

    // A wake-up only comes with a successful unlock.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata[1:0] == ST_OK))
        else $error("wake-up reported with a non-ok status");

    // A reported waiter never has process id zero.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata[13:6] != '0))
        else $error("wake-up reported for process id zero");

    // A nonzero created id only comes with an ok status.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[5:2] != '0)) |-> (o_m_axis_tdata[1:0] == ST_OK))
        else $error("created id set on a failed request");

endmodule
